/* sv/rjb_pkg.sv */
// Package for the RTP jitter reorder buffer: sizes, controller states and the
// command/status structs shared by the controller and the datapath.
`timescale 1ns / 1ps
`default_nettype none
package rjb_pkg;
    localparam int SLOTS = 32;
    localparam int IW    = $clog2(SLOTS);

    typedef logic [IW-1:0] idx_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_FIRST,
        S_CLASS,
        S_JADV,
        S_JREL,
        S_JSTORE,
        S_NWIN,
        S_NADV,
        S_NHEAD,
        S_NCHK,
        S_NSTORE,
        S_REFRESH,
        S_FADV,
        S_OCHK,
        S_OWIN,
        S_OSTORE,
        S_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture the request fields
        logic set_started; // mark the buffer as started
        logic first;       // first packet: set head, tail and newest from the request
        logic touch_idx;   // slot_time[idx] = now
        logic store;       // store the packet at idx
        logic set_tail;    // tail = idx, newest = seq
        logic cur_from_head;
        logic cur_from_tail;
        logic cur_from_tailm1;
        logic cur_inc;
        logic cur_dec;
        logic release_cur; // clear pending at cursor
        logic refresh_cur; // slot_time[cur] = now
        logic head_from_cur;
        logic head_after_tail;
        logic head_inc;
        logic emit;        // emit a handle result from cursor
        logic emit_last;   // emit final status result
        logic status;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic started;
        logic newer;
        logic far;          // distance is SLOTS or more
        logic head_eq_tail;
        logic cur_eq_tail;
        logic cur_eq_idx;
        logic cur_eq_head;
        logic head_eq_idx;
        logic pend_cur;
        logic pend_idx;
        logic expired_cur;
    } stat_t;
endpackage
`default_nettype wire

/* sv/rtp_jitter_reorder_buffer_core.sv */
// RTP jitter reorder buffer top level: controller, datapath, config register
// and result register. The controller's walks (window search, advance,
// refresh) visit one ring slot per cycle. One request at a time; busy is
// high while it runs. Results appear one per cycle with a strobe; the
// receiver cannot stall. Reset: asynchronous, clears pending flags, pointers
// and sets max_wait to 100.
`timescale 1ns / 1ps
`default_nettype none
module rtp_jitter_reorder_buffer_core
    import rjb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [15:0] seq,
    input  wire logic [15:0] packet_handle,
    input  wire logic [31:0] now_ms,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,
    output logic             result_valid,
    output logic             has_packet,
    output logic [15:0]      out_handle,
    output logic             status,
    output logic             last
);
    cmd_t        cmd;
    stat_t       stat;
    logic [15:0] cur_handle;
    logic [15:0] max_wait_reg;

    assign cfg_ready = 1'b1;

    // Wait limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) max_wait_reg <= 16'd100;
        else if (cfg_valid) max_wait_reg <= cfg_data;
    end

    rjb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    rjb_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .seq           (seq),
        .packet_handle (packet_handle),
        .now_ms        (now_ms),
        .max_wait      (max_wait_reg),
        .cmd           (cmd),
        .stat          (stat),
        .cur_handle    (cur_handle)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) result_valid <= 1'b0;
        else result_valid <= cmd.emit || cmd.emit_last;
    end

    always_ff @(posedge clk)
    begin
        has_packet <= cmd.emit;
        out_handle <= cmd.emit ? cur_handle : 16'd0;
        status     <= cmd.emit ? 1'b0 : cmd.status;
        last       <= !cmd.emit;
    end
endmodule
`default_nettype wire

/* sv/rjb_datapath.sv */
// Datapath of the jitter reorder buffer: slot stores, ring pointers and cursor.
// Depends on rjb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rjb_datapath
    import rjb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [15:0] seq,
    input  wire logic [15:0] packet_handle,
    input  wire logic [31:0] now_ms,
    input  wire logic [15:0] max_wait,
    input  wire cmd_t        cmd,
    output stat_t            stat,
    output logic [15:0]      cur_handle
);
    logic [15:0] handle_mem [SLOTS];
    logic [31:0] time_mem   [SLOTS];
    logic [SLOTS-1:0] pend_reg;
    logic [15:0] seq_reg, hdl_reg, newest_reg;
    logic [31:0] now_reg;
    idx_t head_reg, tail_reg, cur_reg, cur_next;
    logic started_reg;
    idx_t idx;
    logic [15:0] d;
    logic [32:0] exp_sum;

    assign idx = seq_reg[IW-1:0];
    assign d   = seq_reg - newest_reg;

    // Request capture and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg    <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            cur_reg     <= '0;
            started_reg <= 1'b0;
            newest_reg  <= '0;
        end
        else
        begin
            if (cmd.set_started) started_reg <= 1'b1;
            if (cmd.first)
            begin
                head_reg   <= idx;
                tail_reg   <= idx;
                newest_reg <= seq_reg;
            end
            if (cmd.set_tail)
            begin
                tail_reg   <= idx;
                newest_reg <= seq_reg;
            end
            if (cmd.release_cur) pend_reg[cur_reg] <= 1'b0;
            if (cmd.store) pend_reg[idx] <= 1'b1;
            if (cmd.head_from_cur) head_reg <= cur_reg;
            else if (cmd.head_after_tail) head_reg <= tail_reg + idx_t'(1);
            else if (cmd.head_inc) head_reg <= head_reg + idx_t'(1);
            cur_reg <= cur_next;
        end
    end

    always_comb
    begin
        cur_next = cur_reg;
        if (cmd.cur_from_head) cur_next = head_reg;
        else if (cmd.cur_from_tail) cur_next = tail_reg;
        else if (cmd.cur_from_tailm1) cur_next = tail_reg - idx_t'(1);
        else if (cmd.cur_inc) cur_next = cur_reg + idx_t'(1);
        else if (cmd.cur_dec) cur_next = cur_reg - idx_t'(1);
    end

    // Payload capture.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            seq_reg <= seq;
            hdl_reg <= packet_handle;
            now_reg <= now_ms;
        end
    end

    // Slot handle and time stores.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++) time_mem[i] <= '0;
        end
        else
        begin
            if (cmd.touch_idx || cmd.store) time_mem[idx] <= now_reg;
            if (cmd.refresh_cur) time_mem[cur_reg] <= now_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store) handle_mem[idx] <= hdl_reg;
    end

    assign exp_sum    = {1'b0, time_mem[cur_reg]} + {17'd0, max_wait};
    assign cur_handle = handle_mem[cur_reg];

    // Status toward the controller.
    always_comb
    begin
        stat.started      = started_reg;
        stat.newer        = (d != 16'd0) && !d[15];
        stat.far          = (d[15] ? (17'h10000 - {1'b0, d}) : {1'b0, d}) >= 17'(SLOTS);
        stat.head_eq_tail = head_reg == tail_reg;
        stat.cur_eq_tail  = cur_reg == tail_reg;
        stat.cur_eq_idx   = cur_reg == idx;
        stat.cur_eq_head  = cur_reg == head_reg;
        stat.head_eq_idx  = head_reg == idx;
        stat.pend_cur     = pend_reg[cur_reg];
        stat.pend_idx     = pend_reg[idx];
        stat.expired_cur  = exp_sum < {1'b0, now_reg};
    end
endmodule
`default_nettype wire

/* sv/rjb_ctrl.sv */
// Controller of the jitter reorder buffer: walks the ring one slot a cycle.
// Depends on rjb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rjb_ctrl
    import rjb_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    output logic       busy,
    input  wire stat_t stat,
    output cmd_t       cmd
);
    state_t state_reg, state_next;
    logic   fadv_reg, fadv_next;   // final advance: stop at gap (not all)

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fadv_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fadv_reg  <= fadv_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        fadv_next  = fadv_reg;
        cmd        = '0;
        busy       = state_reg != S_IDLE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CLASS;
                end
            end
            S_CLASS:
            begin
                if (!stat.started) state_next = S_FIRST;
                else if (stat.newer)
                begin
                    cmd.touch_idx = 1'b1;
                    if (stat.far)
                    begin
                        cmd.cur_from_head = 1'b1;
                        state_next = stat.head_eq_tail ? S_JREL : S_JADV;
                    end
                    else if (stat.head_eq_tail) state_next = S_NCHK;
                    else
                    begin
                        cmd.cur_from_tail = 1'b1;
                        state_next = S_NWIN;
                    end
                end
                else state_next = S_OCHK;
            end
            S_FIRST:
            begin
                cmd.set_started = 1'b1;
                cmd.first  = 1'b1;
                cmd.store  = 1'b1;
                state_next = S_DONE;
            end
            // Jump: release every pending slot from head up to tail.
            S_JADV:
            begin
                if (stat.cur_eq_tail) state_next = S_JREL;
                else
                begin
                    if (stat.pend_cur)
                    begin
                        cmd.emit = 1'b1;
                        cmd.release_cur = 1'b1;
                    end
                    cmd.cur_inc = 1'b1;
                end
            end
            S_JREL:
            begin
                // Cursor sits on the tail slot (or head when equal).
                if (stat.pend_cur)
                begin
                    cmd.emit = 1'b1;
                    cmd.release_cur = 1'b1;
                end
                state_next = S_JSTORE;
            end
            S_JSTORE:
            begin
                cmd.store = 1'b1;
                cmd.set_tail = 1'b1;
                state_next = S_REFRESH;
            end
            // Is head inside [tail, idx)? Cursor walks from tail.
            S_NWIN:
            begin
                if (stat.cur_eq_idx) state_next = S_NHEAD;
                else if (stat.cur_eq_head)
                begin
                    cmd.cur_from_head = 1'b1;
                    state_next = S_NADV;
                end
                else cmd.cur_inc = 1'b1;
            end
            S_NADV:
            begin
                if (stat.cur_eq_idx)
                begin
                    cmd.head_from_cur = 1'b1;
                    state_next = S_NHEAD;
                end
                else
                begin
                    if (stat.pend_cur)
                    begin
                        cmd.emit = 1'b1;
                        cmd.release_cur = 1'b1;
                    end
                    cmd.cur_inc = 1'b1;
                end
            end
            S_NHEAD:
            begin
                if (stat.head_eq_idx)
                begin
                    cmd.cur_from_head = 1'b1;
                    cmd.head_inc = 1'b1;
                    state_next = S_NCHK;
                end
                else state_next = S_NCHK;
            end
            S_NCHK:
            begin
                // Cursor was loaded with the old head when head hit idx.
                if (stat.pend_idx)
                begin
                    if (stat.cur_eq_idx && fadv_reg == 1'b0 && stat.pend_cur)
                    begin
                        cmd.emit = 1'b1;
                        cmd.release_cur = 1'b1;
                        // idx is now empty; store next cycle.
                    end
                    else
                    begin
                        cmd.emit_last = 1'b1;
                        cmd.status = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.store = 1'b1;
                    cmd.set_tail = 1'b1;
                    state_next = S_REFRESH;
                    fadv_next = 1'b1;
                end
            end
            // Refresh gap times from tail-1 back toward head. After a jump the
            // head moves to the slot after the new tail before the walk.
            S_REFRESH:
            begin
                if (!fadv_reg) cmd.head_after_tail = 1'b1;
                state_next = S_NSTORE;
                cmd.cur_from_tailm1 = 1'b1;
            end
            S_NSTORE:
            begin
                if (stat.cur_eq_head || stat.pend_cur)
                begin
                    if (fadv_reg)
                    begin
                        cmd.cur_from_head = 1'b1;
                        state_next = S_FADV;
                    end
                    else
                    begin
                        cmd.head_after_tail = 1'b1;
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    cmd.refresh_cur = 1'b1;
                    cmd.cur_dec = 1'b1;
                end
            end
            // Final advance from head toward tail, stopping at a live gap.
            S_FADV:
            begin
                if (stat.cur_eq_tail && stat.cur_eq_head)
                begin
                    if (stat.pend_cur)
                    begin
                        cmd.emit = 1'b1;
                        cmd.release_cur = 1'b1;
                    end
                    cmd.head_inc = 1'b1;
                    state_next = S_DONE;
                end
                else if (stat.cur_eq_tail)
                begin
                    cmd.head_from_cur = 1'b1;
                    state_next = S_DONE;
                end
                else if (stat.pend_cur)
                begin
                    cmd.emit = 1'b1;
                    cmd.release_cur = 1'b1;
                    cmd.cur_inc = 1'b1;
                end
                else if (stat.expired_cur) cmd.cur_inc = 1'b1;
                else
                begin
                    cmd.head_from_cur = 1'b1;
                    state_next = S_DONE;
                end
            end
            // Older packet checks.
            S_OCHK:
            begin
                if (stat.far || stat.head_eq_tail || stat.pend_idx)
                begin
                    cmd.emit_last = 1'b1;
                    cmd.status = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.cur_from_head = 1'b1;
                    state_next = S_OWIN;
                end
            end
            S_OWIN:
            begin
                if (stat.cur_eq_tail)
                begin
                    cmd.emit_last = 1'b1;
                    cmd.status = 1'b1;
                    state_next = S_IDLE;
                end
                else if (stat.cur_eq_idx) state_next = S_OSTORE;
                else cmd.cur_inc = 1'b1;
            end
            S_OSTORE:
            begin
                cmd.store = 1'b1;
                cmd.cur_from_head = 1'b1;
                fadv_next = 1'b1;
                state_next = S_FADV;
            end
            S_DONE:
            begin
                cmd.emit_last = 1'b1;
                fadv_next = 1'b0;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        if (state_reg == S_IDLE) fadv_next = 1'b0;
    end
endmodule
`default_nettype wire

/* sv/rjb_checker.sv */
// Port-level checker for the jitter reorder buffer, bound to the top level.
// Depends only on the top-level ports.
`timescale 1ns / 1ps
`default_nettype none
module rjb_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic result_valid,
    input wire logic has_packet,
    input wire logic status,
    input wire logic last
);
    // An accepted request makes the block busy.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("busy not raised");
    // A handle result is never the final one.
    a_hl: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && has_packet |-> !last) else $error("handle marked last");
    // Handle results carry status zero.
    a_st: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && has_packet |-> !status) else $error("bad status");
    // After the final result the block is idle.
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |-> !busy) else $error("busy after last");
endmodule

bind rtp_jitter_reorder_buffer_core rjb_checker u_rjb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .has_packet   (has_packet),
    .status       (status),
    .last         (last)
);
`default_nettype wire
